/* rtl/laser_spot_centroid_tracker_top_assert.svh */
// Assertion macros used by the laser spot tracker top level.
// Each macro checks an implication on the rising clock edge, with the check
// held off while the asynchronous reset is asserted.
`ifndef LASER_SPOT_CENTROID_TRACKER_TOP_ASSERT_SVH
`define LASER_SPOT_CENTROID_TRACKER_TOP_ASSERT_SVH

// Same-cycle implication.
`define LSCT_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("lsct assertion failed");

// Next-cycle implication.
`define LSCT_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("lsct assertion failed");

`endif

/* rtl/lsct_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsct_pkg: shared types and constants of the laser spot tracker
// Beat payloads, the frame record passed from front to back, and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package lsct_pkg;

    localparam int CFG_DATA_W  = 21;
    localparam int CFG_INDEX_W = 3;
    localparam int SUM_W       = 32;
    localparam int COUNT_W     = 21;
    localparam int GPIX_W      = 24;
    localparam int GFRM_W      = 16;
    localparam int COORD_W     = 10;

    localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
    localparam logic [GPIX_W-1:0]  GPIX_MAX  = '1;
    localparam logic [GFRM_W-1:0]  GFRM_MAX  = '1;
    localparam logic [7:0]         RUN_MAX   = '1;

    // Reset values of the configuration registers.
    localparam logic [7:0]         GREEN_THRESHOLD_RST = 8'd90;
    localparam logic [COUNT_W-1:0] MIN_SPOT_RST        = 21'd5;
    localparam logic [7:0]         GAP_FRAMES_RST      = 8'd5;
    localparam logic [7:0]         STARTUP_FRAMES_RST  = 8'd5;
    localparam logic [10:0]        WINDOW_END_RST      = 11'd1024;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_GREEN_THRESHOLD  = 3'd0,
        REG_MIN_SPOT_PIXELS  = 3'd1,
        REG_GAP_FRAMES       = 3'd2,
        REG_STARTUP_FRAMES   = 3'd3,
        REG_WINDOW_COL_FIRST = 3'd4,
        REG_WINDOW_COL_END   = 3'd5,
        REG_WINDOW_ROW_FIRST = 3'd6,
        REG_WINDOW_ROW_END   = 3'd7
    } cfg_index_t;

    typedef struct packed {
        logic [7:0]         green;
        logic [COORD_W-1:0] column;
        logic [COORD_W-1:0] line;
        logic               frame_last;
    } pixel_t;

    typedef struct packed {
        logic [COORD_W-1:0] centroid_x;
        logic [COORD_W-1:0] centroid_y;
        logic [COUNT_W-1:0] spot_pixels;
        logic               spot_found;
        logic               gesture_done;
        logic [GPIX_W-1:0]  gesture_pixels;
        logic [GFRM_W-1:0]  gesture_frames;
    } result_t;

    // One finished frame, waiting for its centroid division.
    typedef struct packed {
        logic [SUM_W-1:0]   col_sum;
        logic [SUM_W-1:0]   row_sum;
        logic [COUNT_W-1:0] pix_count;
        logic               spot_found;
        logic               div_en;
        logic               gesture_done;
        logic [GPIX_W-1:0]  gesture_pixels;
        logic [GFRM_W-1:0]  gesture_frames;
    } frame_rec_t;

endpackage
`default_nettype wire

/* rtl/laser_spot_centroid_tracker_top.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// laser_spot_centroid_tracker_top: laser spot centroid and gesture tracker
// Finds the mean position of bright pixels in each difference frame and
// reports frame and gesture summaries.
// ----------------------------------------------------------------------------
// Usage:
// Pixels arrive in raster order on the in_valid/in_ready channel, one beat
// per pixel, with frame_last set on the final pixel of a frame. The block
// takes one pixel beat every cycle; in_ready drops only while both frame
// record slots of the internal queue are occupied.
// Each processed frame end yields exactly one result beat on the
// out_valid/out_ready channel; other pixels, and every pixel of the frames
// skipped after reset, yield none. For each frame record the back end loads
// the record, runs ten steps of the shared restoring divider that forms both
// coordinates, and loads the result register. Frames that arrive faster than
// the back end finishes them are absorbed by the two-entry queue and then
// stall the pixel channel. A result beat waits in its output register while
// out_ready is low; the divider still works through the next record and the
// front keeps taking pixels until the queue is full.
// Reset clears all sums, counters and gesture state and restores the register
// defaults; configuration is written through cfg_we/cfg_index/cfg_data.
// ----------------------------------------------------------------------------
`include "laser_spot_centroid_tracker_top_assert.svh"

module laser_spot_centroid_tracker_top
    import lsct_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire pixel_t                 in_data,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output result_t                     out_data
);

    logic       rec_push;
    logic       rec_full;
    logic       rec_pop;
    logic       rec_valid;
    frame_rec_t push_rec;
    frame_rec_t pop_rec;

    // Front end: window and threshold test, sums, gesture segmentation.
    lsct_front #(
        .MAX_COLUMNS (MAX_COLUMNS),
        .MAX_ROWS    (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .rec_push  (rec_push),
        .rec_data  (push_rec),
        .rec_full  (rec_full)
    );

    // Frame records waiting for division.
    lsct_fifo u_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (rec_push),
        .push_data (push_rec),
        .full      (rec_full),
        .pop       (rec_pop),
        .not_empty (rec_valid),
        .pop_data  (pop_rec)
    );

    // Back end: centroid division and the result register.
    lsct_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .rec_valid (rec_valid),
        .rec_data  (pop_rec),
        .rec_pop   (rec_pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    // The queue is never written while full and never read while empty.
    `LSCT_ASSERT_NOW(a_no_overflow, clk, rst_n, rec_push, !rec_full)
    `LSCT_ASSERT_NOW(a_no_underflow, clk, rst_n, rec_pop, rec_valid)
    // A frame without a spot reports a zero centroid.
    `LSCT_ASSERT_NOW(a_zero_centroid, clk, rst_n, out_valid && !out_data.spot_found,
        out_data.centroid_x == '0 && out_data.centroid_y == '0)
    // Gesture totals are reported only with a finished gesture.
    `LSCT_ASSERT_NOW(a_gesture_totals, clk, rst_n, out_valid && !out_data.gesture_done,
        out_data.gesture_pixels == '0 && out_data.gesture_frames == '0)
    // A spot frame can never close a gesture.
    `LSCT_ASSERT_NOW(a_found_not_done, clk, rst_n, out_valid && out_data.spot_found,
        !out_data.gesture_done)

endmodule
`default_nettype wire

/* rtl/lsct_front.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsct_front: pixel classification, accumulation and gesture tracking
// Holds the configuration registers, sums bright pixels of the current frame
// and emits one frame record at each processed frame end.
// ----------------------------------------------------------------------------
module lsct_front
    import lsct_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_data,
    input  wire logic                   in_valid,
    output logic                        in_ready,
    input  wire pixel_t                 in_data,
    output logic                        rec_push,
    output frame_rec_t                  rec_data,
    input  wire logic                   rec_full
);

    logic [7:0]         green_threshold_reg;
    logic [COUNT_W-1:0] min_spot_reg;
    logic [7:0]         gap_frames_reg;
    logic [7:0]         startup_frames_reg;
    logic [9:0]         col_first_reg;
    logic [10:0]        col_end_reg;
    logic [9:0]         row_first_reg;
    logic [10:0]        row_end_reg;

    logic [SUM_W-1:0]   col_sum_reg, col_sum_next;
    logic [SUM_W-1:0]   row_sum_reg, row_sum_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic [7:0]         startup_cnt_reg, startup_cnt_next;
    logic [7:0]         empty_run_reg, empty_run_next;
    logic               seen_reg, seen_next;
    logic [GPIX_W-1:0]  gpix_reg, gpix_next;
    logic [GFRM_W-1:0]  gfrm_reg, gfrm_next;

    logic               accept, in_startup, bright;
    logic [SUM_W-1:0]   col_sum_cur, row_sum_cur;
    logic [COUNT_W-1:0] count_cur;
    logic               found, gesture_end;
    logic [GPIX_W:0]    gpix_sum;
    logic [GPIX_W-1:0]  gpix_sat;
    logic [GFRM_W-1:0]  gfrm_inc;
    logic [7:0]         run_inc;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            green_threshold_reg <= GREEN_THRESHOLD_RST;
            min_spot_reg        <= MIN_SPOT_RST;
            gap_frames_reg      <= GAP_FRAMES_RST;
            startup_frames_reg  <= STARTUP_FRAMES_RST;
            col_first_reg       <= '0;
            col_end_reg         <= WINDOW_END_RST;
            row_first_reg       <= '0;
            row_end_reg         <= WINDOW_END_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index_t'(cfg_index))
                REG_GREEN_THRESHOLD:  green_threshold_reg <= cfg_data[7:0];
                REG_MIN_SPOT_PIXELS:  min_spot_reg        <= cfg_data;
                REG_GAP_FRAMES:       gap_frames_reg      <= cfg_data[7:0];
                REG_STARTUP_FRAMES:   startup_frames_reg  <= cfg_data[7:0];
                REG_WINDOW_COL_FIRST: col_first_reg       <= cfg_data[9:0];
                REG_WINDOW_COL_END:   col_end_reg         <= cfg_data[10:0];
                REG_WINDOW_ROW_FIRST: row_first_reg       <= cfg_data[9:0];
                REG_WINDOW_ROW_END:   row_end_reg         <= cfg_data[10:0];
                default: ;
            endcase
        end
    end

    assign in_ready   = !rec_full;
    assign accept     = in_valid && in_ready;
    assign in_startup = startup_cnt_reg < startup_frames_reg;

    always_comb
    begin
        bright = (in_data.column >= col_first_reg)
              && ({1'b0, in_data.column} < col_end_reg)
              && (in_data.line >= row_first_reg)
              && ({1'b0, in_data.line} < row_end_reg)
              && (32'(in_data.column) < 32'(MAX_COLUMNS))
              && (32'(in_data.line) < 32'(MAX_ROWS))
              && (in_data.green >= green_threshold_reg)
              && (count_reg != COUNT_MAX);

        col_sum_cur = bright ? col_sum_reg + SUM_W'(in_data.column) : col_sum_reg;
        row_sum_cur = bright ? row_sum_reg + SUM_W'(in_data.line) : row_sum_reg;
        count_cur   = bright ? count_reg + 1'b1 : count_reg;

        found    = count_cur >= min_spot_reg;
        gpix_sum = {1'b0, gpix_reg} + (GPIX_W + 1)'(count_cur);
        gpix_sat = gpix_sum[GPIX_W] ? GPIX_MAX : gpix_sum[GPIX_W-1:0];
        gfrm_inc = (gfrm_reg != GFRM_MAX) ? gfrm_reg + 1'b1 : gfrm_reg;
        run_inc  = (empty_run_reg != RUN_MAX) ? empty_run_reg + 1'b1 : empty_run_reg;
        gesture_end = !found && (run_inc >= gap_frames_reg) && seen_reg;

        col_sum_next     = col_sum_reg;
        row_sum_next     = row_sum_reg;
        count_next       = count_reg;
        startup_cnt_next = startup_cnt_reg;
        empty_run_next   = empty_run_reg;
        seen_next        = seen_reg;
        gpix_next        = gpix_reg;
        gfrm_next        = gfrm_reg;
        rec_push         = 1'b0;

        if (accept)
        begin
            if (in_startup)
            begin
                if (in_data.frame_last && startup_cnt_reg != RUN_MAX)
                begin
                    startup_cnt_next = startup_cnt_reg + 1'b1;
                end
            end
            else if (!in_data.frame_last)
            begin
                col_sum_next = col_sum_cur;
                row_sum_next = row_sum_cur;
                count_next   = count_cur;
            end
            else
            begin
                rec_push     = 1'b1;
                col_sum_next = '0;
                row_sum_next = '0;
                count_next   = '0;
                if (found)
                begin
                    gpix_next      = gpix_sat;
                    gfrm_next      = gfrm_inc;
                    seen_next      = 1'b1;
                    empty_run_next = '0;
                end
                else if (gesture_end)
                begin
                    seen_next      = 1'b0;
                    empty_run_next = '0;
                    gpix_next      = '0;
                    gfrm_next      = '0;
                end
                else
                begin
                    empty_run_next = run_inc;
                end
            end
        end

        rec_data.col_sum        = col_sum_cur;
        rec_data.row_sum        = row_sum_cur;
        rec_data.pix_count      = count_cur;
        rec_data.spot_found     = found;
        rec_data.div_en         = found && (count_cur != '0);
        rec_data.gesture_done   = gesture_end;
        rec_data.gesture_pixels = gesture_end ? gpix_reg : '0;
        rec_data.gesture_frames = gesture_end ? gfrm_reg : '0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_sum_reg     <= '0;
            row_sum_reg     <= '0;
            count_reg       <= '0;
            startup_cnt_reg <= '0;
            empty_run_reg   <= '0;
            seen_reg        <= 1'b0;
            gpix_reg        <= '0;
            gfrm_reg        <= '0;
        end
        else
        begin
            col_sum_reg     <= col_sum_next;
            row_sum_reg     <= row_sum_next;
            count_reg       <= count_next;
            startup_cnt_reg <= startup_cnt_next;
            empty_run_reg   <= empty_run_next;
            seen_reg        <= seen_next;
            gpix_reg        <= gpix_next;
            gfrm_reg        <= gfrm_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/lsct_fifo.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsct_fifo: two-entry queue of frame records
// Decouples the pixel front end from the centroid divider.
// ----------------------------------------------------------------------------
module lsct_fifo
    import lsct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  wire frame_rec_t push_data,
    output logic            full,
    input  wire logic       pop,
    output logic            not_empty,
    output frame_rec_t      pop_data
);

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    frame_rec_t         entries_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [PTR_W:0]     fill_reg, fill_next;

    assign full      = fill_reg == (PTR_W + 1)'(DEPTH);
    assign not_empty = fill_reg != '0;
    assign pop_data  = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        fill_next   = fill_reg + (PTR_W + 1)'(push) - (PTR_W + 1)'(pop);
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule
`default_nettype wire

/* rtl/lsct_back.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// lsct_back: centroid divider and result register
// Divides both coordinate sums by the pixel count, one quotient bit per
// cycle for each axis, and holds the result beat until it is taken.
// ----------------------------------------------------------------------------
module lsct_back
    import lsct_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rec_valid,
    input  wire frame_rec_t rec_data,
    output logic            rec_pop,
    output logic            out_valid,
    input  wire logic       out_ready,
    output result_t         out_data
);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_DIV  = 3'b010,
        ST_SEND = 3'b100
    } back_state_t;

    localparam logic [3:0] LAST_STEP = 4'(COORD_W - 1);

    back_state_t        state_reg, state_next;
    logic [3:0]         step_reg, step_next;
    frame_rec_t         rec_reg, rec_next;
    logic [SUM_W-1:0]   rem_x_reg, rem_x_next;
    logic [SUM_W-1:0]   rem_y_reg, rem_y_next;
    logic [COORD_W-1:0] qx_reg, qx_next;
    logic [COORD_W-1:0] qy_reg, qy_next;
    logic               out_valid_reg, out_valid_next;
    result_t            out_data_reg, out_data_next;

    logic [SUM_W-1:0]   divisor_sh;
    logic               bit_x, bit_y;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    always_comb
    begin
        divisor_sh = SUM_W'(rec_reg.pix_count) << step_reg;
        bit_x      = rem_x_reg >= divisor_sh;
        bit_y      = rem_y_reg >= divisor_sh;

        state_next     = state_reg;
        step_next      = step_reg;
        rec_next       = rec_reg;
        rem_x_next     = rem_x_reg;
        rem_y_next     = rem_y_reg;
        qx_next        = qx_reg;
        qy_next        = qy_reg;
        out_data_next  = out_data_reg;
        out_valid_next = out_valid_reg && !out_ready;
        rec_pop        = 1'b0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (rec_valid)
                begin
                    rec_pop    = 1'b1;
                    rec_next   = rec_data;
                    rem_x_next = rec_data.col_sum;
                    rem_y_next = rec_data.row_sum;
                    qx_next    = '0;
                    qy_next    = '0;
                    step_next  = LAST_STEP;
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                rem_x_next = bit_x ? rem_x_reg - divisor_sh : rem_x_reg;
                rem_y_next = bit_y ? rem_y_reg - divisor_sh : rem_y_reg;
                qx_next    = {qx_reg[COORD_W-2:0], bit_x};
                qy_next    = {qy_reg[COORD_W-2:0], bit_y};
                step_next  = step_reg - 1'b1;
                if (step_reg == '0)
                begin
                    state_next = ST_SEND;
                end
            end
            ST_SEND:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next               = 1'b1;
                    out_data_next.centroid_x     = rec_reg.div_en ? qx_reg : '0;
                    out_data_next.centroid_y     = rec_reg.div_en ? qy_reg : '0;
                    out_data_next.spot_pixels    = rec_reg.pix_count;
                    out_data_next.spot_found     = rec_reg.spot_found;
                    out_data_next.gesture_done   = rec_reg.gesture_done;
                    out_data_next.gesture_pixels = rec_reg.gesture_pixels;
                    out_data_next.gesture_frames = rec_reg.gesture_frames;
                    state_next                   = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rec_reg      <= rec_next;
        rem_x_reg    <= rem_x_next;
        rem_y_reg    <= rem_y_next;
        qx_reg       <= qx_next;
        qy_reg       <= qy_next;
        out_data_reg <= out_data_next;
    end

endmodule
`default_nettype wire

/* bench/laser_spot_centroid_tracker_checker.sv */
// ----------------------------------------------------------------------------
// Laser spot tracker checker
// Watches the pixel, result and register channels of the tracker, predicts
// the frame report of every frame end past the startup frames and compares
// each result beat against the oldest outstanding report, field by field.
// ----------------------------------------------------------------------------
module laser_spot_centroid_tracker_checker
    import lsct_pkg::*;
#(
    parameter int MAX_COLUMNS = 1024,
    parameter int MAX_ROWS    = 1024
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_we,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    input  logic                   in_ready,
    input  pixel_t                 in_data,
    input  logic                   out_valid,
    input  logic                   out_ready,
    input  result_t                out_data,
    output int                     fail_count,
    output int                     results_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    // Register mirror.
    logic [7:0]         green_min;
    logic [COUNT_W-1:0] spot_min;
    logic [7:0]         gap_len;
    logic [7:0]         startup_len;
    logic [9:0]         col_lo;
    logic [10:0]        col_hi;
    logic [9:0]         row_lo;
    logic [10:0]        row_hi;

    // Frame and gesture state.
    logic [SUM_W-1:0]   col_acc;
    logic [SUM_W-1:0]   row_acc;
    logic [COUNT_W-1:0] bright_pixels;
    logic [7:0]         frames_skipped;
    logic [7:0]         dark_run;
    logic               spot_seen;
    logic [GPIX_W-1:0]  gesture_pix;
    logic [GFRM_W-1:0]  gesture_frm;

    result_t frame_reports[$];
    int      bad_reports;

    task automatic note_failure(input string msg);
        if (bad_reports < 10)
        begin
            $display("[%0t] %s", $realtime, msg);
        end
        bad_reports++;
    endtask

    task automatic restore_defaults();
        green_min      = GREEN_THRESHOLD_RST;
        spot_min       = MIN_SPOT_RST;
        gap_len        = GAP_FRAMES_RST;
        startup_len    = STARTUP_FRAMES_RST;
        col_lo         = '0;
        col_hi         = WINDOW_END_RST;
        row_lo         = '0;
        row_hi         = WINDOW_END_RST;
        col_acc        = '0;
        row_acc        = '0;
        bright_pixels  = '0;
        frames_skipped = '0;
        dark_run       = '0;
        spot_seen      = 1'b0;
        gesture_pix    = '0;
        gesture_frm    = '0;
    endtask

    task automatic write_mirror(input cfg_index_t idx, input logic [CFG_DATA_W-1:0] value);
        case (idx)
            REG_GREEN_THRESHOLD:  green_min   = value[7:0];
            REG_MIN_SPOT_PIXELS:  spot_min    = value[COUNT_W-1:0];
            REG_GAP_FRAMES:       gap_len     = value[7:0];
            REG_STARTUP_FRAMES:   startup_len = value[7:0];
            REG_WINDOW_COL_FIRST: col_lo      = value[9:0];
            REG_WINDOW_COL_END:   col_hi      = value[10:0];
            REG_WINDOW_ROW_FIRST: row_lo      = value[9:0];
            REG_WINDOW_ROW_END:   row_hi      = value[10:0];
            default: ;
        endcase
    endtask

    // Accumulates one pixel beat and, on a frame end past the startup frames, queues the frame report.
    task automatic track_pixel(input pixel_t px);
        logic             bright;
        logic             found;
        logic [SUM_W-1:0] quot;
        logic [GPIX_W:0]  gsum;
        result_t          rep;
        if (frames_skipped < startup_len)
        begin
            if (px.frame_last && frames_skipped != RUN_MAX)
            begin
                frames_skipped++;
            end
        end
        else
        begin
            bright = px.column >= col_lo && {1'b0, px.column} < col_hi
                  && px.line >= row_lo && {1'b0, px.line} < row_hi
                  && int'(px.column) < MAX_COLUMNS && int'(px.line) < MAX_ROWS
                  && px.green >= green_min && bright_pixels != COUNT_MAX;
            if (bright)
            begin
                bright_pixels++;
                col_acc += SUM_W'(px.column);
                row_acc += SUM_W'(px.line);
            end
            if (px.frame_last)
            begin
                rep = '0;
                rep.spot_pixels = bright_pixels;
                found = bright_pixels >= spot_min;
                rep.spot_found = found;
                if (found)
                begin
                    if (bright_pixels != '0)
                    begin
                        quot = col_acc / {11'd0, bright_pixels};
                        rep.centroid_x = quot[COORD_W-1:0];
                        quot = row_acc / {11'd0, bright_pixels};
                        rep.centroid_y = quot[COORD_W-1:0];
                    end
                    gsum = {1'b0, gesture_pix} + {4'd0, bright_pixels};
                    gesture_pix = gsum[GPIX_W] ? GPIX_MAX : gsum[GPIX_W-1:0];
                    if (gesture_frm != GFRM_MAX)
                    begin
                        gesture_frm++;
                    end
                    spot_seen = 1'b1;
                    dark_run  = '0;
                end
                else
                begin
                    if (dark_run != RUN_MAX)
                    begin
                        dark_run++;
                    end
                    if (dark_run >= gap_len && spot_seen)
                    begin
                        rep.gesture_done   = 1'b1;
                        rep.gesture_pixels = gesture_pix;
                        rep.gesture_frames = gesture_frm;
                        spot_seen   = 1'b0;
                        dark_run    = '0;
                        gesture_pix = '0;
                        gesture_frm = '0;
                    end
                end
                col_acc       = '0;
                row_acc       = '0;
                bright_pixels = '0;
                frame_reports.insert(frame_reports.size(), rep);
            end
        end
    endtask

    task automatic check_report(input result_t got);
        result_t want;
        if (frame_reports.size() == 0)
        begin
            note_failure($sformatf("unexpected result beat: x=%0d y=%0d pix=%0d found=%0d",
                got.centroid_x, got.centroid_y, got.spot_pixels, got.spot_found));
        end
        else
        begin
            want = frame_reports.pop_front();
            if (got.centroid_x !== want.centroid_x || got.centroid_y !== want.centroid_y
                || got.spot_pixels !== want.spot_pixels || got.spot_found !== want.spot_found
                || got.gesture_done !== want.gesture_done
                || got.gesture_pixels !== want.gesture_pixels
                || got.gesture_frames !== want.gesture_frames)
            begin
                note_failure($sformatf({"result mismatch: expected x=%0d y=%0d pix=%0d ",
                    "found=%0d done=%0d gpix=%0d gfrm=%0d, got x=%0d y=%0d pix=%0d ",
                    "found=%0d done=%0d gpix=%0d gfrm=%0d"},
                    want.centroid_x, want.centroid_y, want.spot_pixels, want.spot_found,
                    want.gesture_done, want.gesture_pixels, want.gesture_frames,
                    got.centroid_x, got.centroid_y, got.spot_pixels, got.spot_found,
                    got.gesture_done, got.gesture_pixels, got.gesture_frames));
            end
        end
    endtask

    // The result beat is checked before the pixel beat of the same edge so
    // that a stray result can never match a report queued in that cycle.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            restore_defaults();
            frame_reports.delete();
            bad_reports = 0;
        end
        else
        begin
            if (cfg_we)
            begin
                write_mirror(cfg_index_t'(cfg_index), cfg_data);
            end
            if (out_valid && out_ready)
            begin
                check_report(out_data);
            end
            if (in_valid && in_ready)
            begin
                track_pixel(in_data);
            end
        end
        fail_count      <= bad_reports;
        results_pending <= frame_reports.size();
    end

endmodule

/* bench/laser_spot_centroid_tracker_top_test.sv */
// ----------------------------------------------------------------------------
// Laser spot tracker testbench
// Drives pixel beats through a series of register settings, starting with a
// short directed sequence and then random frames, while the result channel
// stalls on its own pattern. A checker beside the block predicts and
// compares every result beat; this module makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module laser_spot_centroid_tracker_top_test;
    timeunit 1ns;
    timeprecision 1ps;

    import lsct_pkg::*;

    localparam int CLK_PERIOD       = 10;
    localparam int RESET_CYCLES     = 12;
    // A result leaves once its record has passed through the queue and the back
    // end, and queued records can keep the block busy for longer.
    localparam int SETTLE_CYCLES    = 40;
    localparam int RUN_LIMIT_NS     = 10_000_000;
    localparam int LONG_HOLD_AT     = 600;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int NUM_PLANS        = 8;
    localparam int MAX_COLUMNS      = 1024;
    localparam int MAX_ROWS         = 1024;

    typedef enum int {FRAME_BRIGHT, FRAME_DARK, FRAME_MIXED} frame_kind_t;

    // One register setting and the random traffic that runs under it.
    typedef struct packed {
        int threshold;
        int min_pixels;
        int gap;
        int startup;
        int col_first;
        int col_end;
        int row_first;
        int row_end;
        int items;
        int max_len;
    } phase_plan_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    cfg_index_t cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic       in_valid;
    logic       in_ready;
    pixel_t     in_data;
    logic       out_valid;
    logic       out_ready;
    result_t    out_data;

    int          mismatches;
    int          reports_outstanding;
    int          pixels_accepted;
    int          burst_left;
    logic        long_hold_done;
    phase_plan_t plans [NUM_PLANS];
    phase_plan_t live;

    laser_spot_centroid_tracker_top #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .in_data  (in_data),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .out_data (out_data)
    );

    laser_spot_centroid_tracker_checker #(
        .MAX_COLUMNS(MAX_COLUMNS),
        .MAX_ROWS   (MAX_ROWS)
    ) u_checker (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .in_valid       (in_valid),
        .in_ready       (in_ready),
        .in_data        (in_data),
        .out_valid      (out_valid),
        .out_ready      (out_ready),
        .out_data       (out_data),
        .fail_count     (mismatches),
        .results_pending(reports_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #(CLK_PERIOD / 2) clk = ~clk;
    end

    // Hard stop in case the block hangs or drops results.
    initial
    begin
        #(RUN_LIMIT_NS);
        $display("CHECKS FAILED");
        $finish;
    end

    function automatic pixel_t pixel_at(input int green, input int column, input int line,
                                        input bit last);
        pixel_t px;
        px.green      = green[7:0];
        px.column     = column[9:0];
        px.line       = line[9:0];
        px.frame_last = last;
        return px;
    endfunction

    // Picks a coordinate around a window span: mostly inside it, with the
    // span's ends and the positions just outside them favored.
    function automatic int pick_coord(input int lo, input int hi);
        int pick;
        pick = $urandom_range(0, 7);
        case (pick)
            0: pick = lo;
            1: pick = hi;
            2: pick = lo - 1;
            3: pick = hi + 1;
            default: pick = $urandom_range(lo, hi);
        endcase
        if (pick < 0)
        begin
            pick = 0;
        end
        if (pick > 1023)
        begin
            pick = 1023;
        end
        return pick;
    endfunction

    // Builds one pixel of the given frame kind against the live setting.
    // Bright pixels aim at the window with a green value at or above the
    // threshold, dark pixels stay below it when it is above zero, mixed pixels are noise.
    function automatic pixel_t make_pixel(input frame_kind_t kind);
        pixel_t px;
        int     hi_c;
        int     hi_r;
        hi_c = (live.col_end > 1024 ? 1024 : live.col_end) - 1;
        hi_r = (live.row_end > 1024 ? 1024 : live.row_end) - 1;
        px.frame_last = 1'b0;
        px.green      = 8'($urandom_range(0, 255));
        px.column     = 10'($urandom_range(0, 1023));
        px.line       = 10'($urandom_range(0, 1023));
        if (kind == FRAME_BRIGHT)
        begin
            px.green = 8'($urandom_range(live.threshold, 255));
        end
        else if (kind == FRAME_DARK && live.threshold > 0)
        begin
            px.green = 8'($urandom_range(0, live.threshold - 1));
        end
        if (kind == FRAME_BRIGHT || $urandom_range(0, 1) == 0)
        begin
            px.column = 10'(pick_coord(live.col_first, hi_c));
            px.line   = 10'(pick_coord(live.row_first, hi_r));
        end
        return px;
    endfunction

    // Offers one pixel beat and returns at the edge that accepts it. The
    // sender works in bursts; between bursts valid may drop for a random gap.
    task automatic offer_pixel(input pixel_t px);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                in_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(100, 300)
                                                     : $urandom_range(1, 30);
        end
        in_valid <= 1'b1;
        in_data  <= px;
        @(posedge clk);
        while (!in_ready)
        begin
            @(posedge clk);
        end
        burst_left--;
        pixels_accepted++;
    endtask

    // Random frames until the item budget is spent. The frame kind is kept
    // for a few frames at a time so that spot runs and empty runs are long
    // enough to open and close gestures.
    task automatic send_frames(input int items, input int max_len);
        int          sent;
        int          len;
        int          run_left;
        int          pick;
        frame_kind_t kind;
        pixel_t      px;
        sent     = 0;
        run_left = 0;
        kind     = FRAME_BRIGHT;
        while (sent < items)
        begin
            if (run_left == 0)
            begin
                pick = $urandom_range(0, 9);
                kind = (pick < 4) ? FRAME_BRIGHT : (pick < 8) ? FRAME_DARK : FRAME_MIXED;
                run_left = $urandom_range(1, 6);
            end
            run_left--;
            len = $urandom_range(1, max_len);
            for (int i = 0; i < len; i++)
            begin
                px = make_pixel(kind);
                px.frame_last = (i == len - 1);
                offer_pixel(px);
                sent++;
            end
        end
    endtask

    // Waits until every predicted result has arrived and the back end has had
    // time to finish any frame that produces no result.
    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        wait (reports_outstanding == 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // One register write per edge; cfg_we stays high across a series and is
    // lowered by the caller after the last write.
    task automatic write_reg(input cfg_index_t idx, input int value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= value[CFG_DATA_W-1:0];
        @(posedge clk);
    endtask

    task automatic program_plan(input phase_plan_t plan);
        live = plan;
        write_reg(REG_GREEN_THRESHOLD, plan.threshold);
        write_reg(REG_MIN_SPOT_PIXELS, plan.min_pixels);
        write_reg(REG_GAP_FRAMES, plan.gap);
        write_reg(REG_STARTUP_FRAMES, plan.startup);
        write_reg(REG_WINDOW_COL_FIRST, plan.col_first);
        write_reg(REG_WINDOW_COL_END, plan.col_end);
        write_reg(REG_WINDOW_ROW_FIRST, plan.row_first);
        write_reg(REG_WINDOW_ROW_END, plan.row_end);
        cfg_we <= 1'b0;
    endtask

    // Result receiver. It switches between always ready, about half ready,
    // rarely ready and mostly ready in spans of random length. Once enough
    // pixel beats have gone in, it holds ready low for a long stretch so that
    // the frame queue fills and the block pushes back on the pixel channel.
    initial
    begin : receiver
        int mode;
        int span;
        out_ready      <= 1'b0;
        long_hold_done  = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            if (!long_hold_done && pixels_accepted >= LONG_HOLD_AT)
            begin
                out_ready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold_done = 1'b1;
            end
            mode = $urandom_range(0, 3);
            span = $urandom_range(8, 60);
            repeat (span)
            begin
                case (mode)
                    0: out_ready <= 1'b1;
                    1: out_ready <= ($urandom_range(0, 1) == 1);
                    2: out_ready <= ($urandom_range(0, 3) == 0);
                    default: out_ready <= ($urandom_range(0, 7) != 0);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        rst_n           <= 1'b0;
        cfg_we          <= 1'b0;
        cfg_index       <= REG_GREEN_THRESHOLD;
        cfg_data        <= '0;
        in_valid        <= 1'b0;
        in_data         <= '0;
        pixels_accepted  = 0;
        burst_left       = 0;

        // Settings: threshold, minimum, gap, startup, column window, row
        // window, random items and longest frame. The first one holds the
        // reset values, which are exercised without any write.
        plans[0] = '{90, 5, 5, 5, 0, 1024, 0, 1024, 270, 10};
        // Threshold zero, windows that reach past the frame edge, gap of one.
        plans[1] = '{0, 1, 1, 5, 0, 2047, 0, 2047, 240, 8};
        // Top threshold, zero minimum, zero gap, three more startup frames.
        plans[2] = '{255, 0, 0, 8, 100, 400, 50, 300, 240, 4};
        // Inverted column window: nothing can count.
        plans[3] = '{128, 3, 3, 0, 600, 200, 0, 1024, 150, 8};
        // Empty column window with zero minimum: every frame is a spot at 0,0.
        plans[4] = '{50, 0, 2, 0, 300, 300, 1023, 1024, 150, 6};
        // Startup raised to its top: the block skips frames again until its
        // counter reaches the limit. Window of one pixel at the frame corner.
        plans[5] = '{60, 2, 255, 255, 1023, 1024, 0, 1, 470, 2};
        // Minimum far above any frame length: no frame is a spot, so an open gesture closes.
        plans[6] = '{1, 1048576, 1, 5, 0, 1024, 0, 1024, 100, 3};
        plans[7] = '{90, 4, 2, 0, 0, 1024, 0, 1024, 300, 12};

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        live = plans[0];

        // Startup frames after reset: bright pixels that must be ignored.
        offer_pixel(pixel_at(255, 5, 5, 1'b0));
        offer_pixel(pixel_at(255, 6, 5, 1'b1));
        offer_pixel(pixel_at(255, 1023, 1023, 1'b1));
        offer_pixel(pixel_at(255, 0, 0, 1'b1));
        offer_pixel(pixel_at(200, 512, 512, 1'b1));
        offer_pixel(pixel_at(255, 1, 1, 1'b1));
        // A spot at exactly the minimum count, built from the frame corners,
        // a pixel one below the threshold and a bright frame-end pixel.
        offer_pixel(pixel_at(255, 0, 0, 1'b0));
        offer_pixel(pixel_at(255, 1023, 1023, 1'b0));
        offer_pixel(pixel_at(90, 1023, 0, 1'b0));
        offer_pixel(pixel_at(89, 512, 512, 1'b0));
        offer_pixel(pixel_at(90, 0, 1023, 1'b0));
        offer_pixel(pixel_at(255, 511, 511, 1'b1));
        // One frame below the minimum, then empty frames up to the gap, which
        // closes the gesture on the fifth.
        offer_pixel(pixel_at(255, 100, 100, 1'b1));
        offer_pixel(pixel_at(0, 0, 0, 1'b1));
        offer_pixel(pixel_at(89, 1023, 1023, 1'b1));
        offer_pixel(pixel_at(0, 1023, 0, 1'b1));
        offer_pixel(pixel_at(0, 0, 1023, 1'b1));

        send_frames(plans[0].items, plans[0].max_len);
        for (int p = 1; p < NUM_PLANS; p++)
        begin
            drain();
            program_plan(plans[p]);
            send_frames(plans[p].items, plans[p].max_len);
        end
        drain();

        if (mismatches == 0 && reports_outstanding == 0)
        begin
            $display("ALL CHECKS PASSED");
        end
        else
        begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
